/* rtl/jph_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job priority heap package
// Shared widths, record type, status codes and the control and status
// bundles between the heap controller and its datapath.
// ----------------------------------------------------------------------------
package jph_pkg;

  localparam int PRIO_W  = 8;
  localparam int PROC_W  = 22;
  localparam int SRCN_W  = 8;
  localparam int WTIME_W = 4;
  localparam int TAG_W   = 17;
  localparam int CNT_W   = 8;
  localparam int STS_W   = 2;
  localparam int IDX_W   = CNT_W + 1;

  localparam int          HEAP_DEPTH_DEF = 128;
  localparam logic [CNT_W-1:0] CAP_RESET = 8'd8;

  localparam logic [STS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic MODE_INSERT = 1'b0;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [PROC_W-1:0]  proc;
    logic [SRCN_W-1:0]  srcn;
    logic [WTIME_W-1:0] wtime;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic             load;
    logic             start_ins;
    logic             start_del;
    logic             del_last;
    logic             del_root;
    logic             del_move;
    logic             dn_rd_r;
    logic             dn_rd_l;
    logic             dn_cmp_l;
    logic             up_rd;
    logic             up_cmp;
    logic             finish;
    logic [STS_W-1:0] res_code;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic full;
    logic empty;
    logic up_at_root;
    logic up_stop;
    logic dn_stop;
  } sts_t;

endpackage

/* rtl/jph_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job request channel
// Valid and ready handshake carrying one heap operation and its job record.
// ----------------------------------------------------------------------------
interface jph_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [jph_pkg::PRIO_W-1:0]    job_priority;
  logic [jph_pkg::PROC_W-1:0]    source_process;
  logic [jph_pkg::SRCN_W-1:0]    source_number;
  logic [jph_pkg::WTIME_W-1:0]   work_time;
  logic [jph_pkg::TAG_W-1:0]     job_tag;

  modport source (
    output valid, mode, job_priority, source_process, source_number, work_time, job_tag,
    input  ready
  );
  modport sink (
    input  valid, mode, job_priority, source_process, source_number, work_time, job_tag,
    output ready
  );
endinterface

/* rtl/jph_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job result channel
// Valid and ready handshake carrying the status, removed job and fill level.
// ----------------------------------------------------------------------------
interface jph_out_if;
  logic                          valid;
  logic                          ready;
  logic [jph_pkg::STS_W-1:0]     status;
  logic [jph_pkg::PRIO_W-1:0]    out_priority;
  logic [jph_pkg::PROC_W-1:0]    out_process;
  logic [jph_pkg::SRCN_W-1:0]    out_source_number;
  logic [jph_pkg::WTIME_W-1:0]   out_work_time;
  logic [jph_pkg::TAG_W-1:0]     out_job_tag;
  logic [jph_pkg::CNT_W-1:0]     entries_after;

  modport source (
    output valid, status, out_priority, out_process, out_source_number, out_work_time,
           out_job_tag, entries_after,
    input  ready
  );
  modport sink (
    input  valid, status, out_priority, out_process, out_source_number, out_work_time,
           out_job_tag, entries_after,
    output ready
  );
endinterface

/* rtl/jph_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/jph_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job priority heap datapath
// Heap store, entry count, capacity register, moving record and the
// comparisons for sifting up and down; result registers for the output.
// ----------------------------------------------------------------------------
module jph_datapath #(
  parameter int HEAP_DEPTH = jph_pkg::HEAP_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  jph_pkg::cmd_t              cmd,
  output jph_pkg::sts_t              sts,
  input  logic                       in_mode,
  input  jph_pkg::rec_t              in_rec,
  input  logic                       cfg_we,
  input  logic [jph_pkg::CNT_W-1:0]  cfg_wdata,
  output logic [jph_pkg::STS_W-1:0]  res_status,
  output jph_pkg::rec_t              res_job,
  output logic [jph_pkg::CNT_W-1:0]  res_count
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int IW = jph_pkg::IDX_W;

  logic [jph_pkg::CNT_W-1:0] cap;
  logic [jph_pkg::CNT_W-1:0] count;
  logic                      mode;
  jph_pkg::rec_t             mov;
  jph_pkg::rec_t             top_job;
  jph_pkg::rec_t             best_rec;
  logic                      best_child;
  logic [IW-1:0]             idx;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  jph_pkg::rec_t             ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  jph_pkg::rec_t             rdata;
  logic [jph_pkg::REC_W-1:0] rdata_raw;

  logic [IW-1:0]             lc;
  logic [IW-1:0]             rc;
  logic [IW-1:0]             par;
  logic [IW-1:0]             count_ext;
  logic                      lc_ok;
  logic                      rc_ok;
  logic                      sel_l;
  logic [jph_pkg::PRIO_W-1:0] best_prio;

  assign rdata     = jph_pkg::rec_t'(rdata_raw);
  assign count_ext = {1'b0, count};
  assign lc        = {idx[IW-2:0], 1'b1};
  assign rc        = lc + IW'(1);
  assign par       = (idx - IW'(1)) >> 1;
  assign lc_ok     = lc < count_ext;
  assign rc_ok     = rc < count_ext;
  assign best_prio = best_child ? best_rec.prio : mov.prio;
  assign sel_l     = lc_ok && (best_prio < rdata.prio);

  always_comb begin
    sts.mode       = mode;
    sts.full       = !((count < cap) && (32'(count) < HEAP_DEPTH));
    sts.empty      = (count == '0);
    sts.up_at_root = (idx == '0);
    sts.up_stop    = !(mov.prio > rdata.prio);
    sts.dn_stop    = !sel_l && !best_child;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(idx);
    ram_wdata = mov;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd.start_del) begin
      ram_re = 1'b1;
    end
    if (cmd.del_last) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(count - jph_pkg::CNT_W'(1));
    end
    if (cmd.dn_rd_r) begin
      ram_re    = rc_ok;
      ram_raddr = AW'(rc);
    end
    if (cmd.dn_rd_l) begin
      ram_re    = lc_ok;
      ram_raddr = AW'(lc);
    end
    if (cmd.dn_cmp_l) begin
      ram_we = 1'b1;
      if (!sts.dn_stop) begin
        ram_wdata = sel_l ? rdata : best_rec;
      end
    end
    if (cmd.up_rd) begin
      ram_we    = sts.up_at_root;
      ram_re    = !sts.up_at_root;
      ram_raddr = AW'(par);
    end
    if (cmd.up_cmp) begin
      ram_we = 1'b1;
      if (!sts.up_stop) begin
        ram_wdata = rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= jph_pkg::CAP_RESET;
      count <= '0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (cmd.start_ins) begin
        count <= count + jph_pkg::CNT_W'(1);
      end
      if (cmd.del_last) begin
        count <= count - jph_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mov     <= in_rec;
      mode    <= in_mode;
      top_job <= '0;
    end
    if (cmd.start_ins) begin
      idx <= count_ext;
    end
    if (cmd.del_root) begin
      top_job <= rdata;
    end
    if (cmd.del_move) begin
      mov <= rdata;
      idx <= '0;
    end
    if (cmd.dn_rd_l) begin
      best_child <= rc_ok && (mov.prio < rdata.prio);
      best_rec   <= rdata;
    end
    if (cmd.dn_cmp_l && !sts.dn_stop) begin
      idx <= sel_l ? lc : rc;
    end
    if (cmd.up_cmp && !sts.up_stop) begin
      idx <= par;
    end
    if (cmd.finish) begin
      res_status <= cmd.res_code;
      res_job    <= top_job;
      res_count  <= count;
    end
  end

  jph_ram #(
    .WIDTH (jph_pkg::REC_W),
    .DEPTH (HEAP_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata_raw)
  );

endmodule

/* rtl/jph_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job priority heap controller
// Sequences one insert or delete at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module jph_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  jph_pkg::sts_t sts,
  output jph_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_DEL_LAST = 4'd2;
  localparam logic [3:0] S_DEL_MOVE = 4'd3;
  localparam logic [3:0] S_DN_RD_R  = 4'd4;
  localparam logic [3:0] S_DN_RD_L  = 4'd5;
  localparam logic [3:0] S_DN_CMP_L = 4'd6;
  localparam logic [3:0] S_UP_RD    = 4'd7;
  localparam logic [3:0] S_UP_CMP   = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0]                state;
  logic [3:0]                state_next;
  logic [jph_pkg::STS_W-1:0] code;
  logic [jph_pkg::STS_W-1:0] code_next;
  logic                      slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    code_next    = code;
    cmd          = '0;
    cmd.res_code = code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        code_next = jph_pkg::ST_DONE;
        if (sts.mode == jph_pkg::MODE_INSERT) begin
          if (sts.full) begin
            code_next  = jph_pkg::ST_FULL;
            state_next = S_FINISH;
          end else begin
            cmd.start_ins = 1'b1;
            state_next    = S_UP_RD;
          end
        end else begin
          if (sts.empty) begin
            code_next  = jph_pkg::ST_EMPTY;
            state_next = S_FINISH;
          end else begin
            cmd.start_del = 1'b1;
            state_next    = S_DEL_LAST;
          end
        end
      end
      S_DEL_LAST: begin
        cmd.del_root = 1'b1;
        cmd.del_last = 1'b1;
        state_next   = S_DEL_MOVE;
      end
      S_DEL_MOVE: begin
        cmd.del_move = 1'b1;
        state_next   = S_DN_RD_R;
      end
      S_DN_RD_R: begin
        cmd.dn_rd_r = 1'b1;
        state_next  = S_DN_RD_L;
      end
      S_DN_RD_L: begin
        cmd.dn_rd_l = 1'b1;
        state_next  = S_DN_CMP_L;
      end
      S_DN_CMP_L: begin
        cmd.dn_cmp_l = 1'b1;
        state_next   = sts.dn_stop ? S_FINISH : S_DN_RD_R;
      end
      S_UP_RD: begin
        cmd.up_rd  = 1'b1;
        state_next = sts.up_at_root ? S_FINISH : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_next = sts.up_stop ? S_FINISH : S_UP_RD;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      code      <= jph_pkg::ST_DONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_accept_decides: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECIDE))
    else $error("Accepted beat did not move the controller to the decision step.");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("Result became valid outside the finishing step.");

  a_finish_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == S_IDLE) && out_valid)
    else $error("Finished operation did not present its result and return to idle.");
`endif

endmodule

/* rtl/job_priority_heap_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job priority heap unit
// Binary max-heap of job records keyed on priority, with insert and delete.
// ----------------------------------------------------------------------------
// One operation is handled at a time and every operation returns exactly one
// result beat. The heap lives in a single RAM with one write and one
// registered read port, and the moving record is carried in a register while
// the others shift past it. An insert walks the heap up and a delete walks it
// down level by level; the pace is set by the one RAM read port, with two
// reads per level going down. A new request is taken once the previous
// operation has finished, even while its result still waits in the output
// register. Inserts are rejected with a full status once the count reaches
// the smaller of the capacity register and HEAP_DEPTH, and a delete on an
// empty heap returns an empty status with zero job fields.
// ----------------------------------------------------------------------------
module job_priority_heap_unit #(
  parameter int HEAP_DEPTH = jph_pkg::HEAP_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  jph_in_if.sink                    job,
  jph_out_if.source                 result,
  input  logic                      cfg_we,
  input  logic [jph_pkg::CNT_W-1:0] cfg_wdata
);

  jph_pkg::cmd_t cmd;
  jph_pkg::sts_t sts;
  jph_pkg::rec_t in_rec;
  jph_pkg::rec_t res_job;

  assign in_rec.prio  = job.job_priority;
  assign in_rec.proc  = job.source_process;
  assign in_rec.srcn  = job.source_number;
  assign in_rec.wtime = job.work_time;
  assign in_rec.tag   = job.job_tag;

  assign result.out_priority      = res_job.prio;
  assign result.out_process       = res_job.proc;
  assign result.out_source_number = res_job.srcn;
  assign result.out_work_time     = res_job.wtime;
  assign result.out_job_tag       = res_job.tag;

  jph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (job.valid),
    .in_ready  (job.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  jph_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (job.mode),
    .in_rec     (in_rec),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res_status (result.status),
    .res_job    (res_job),
    .res_count  (result.entries_after)
  );

endmodule
